// ----- sv/assert_macros.svh -----
// Assertion macros for the biquad cascade unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BCS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BCS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCS_ASSERT(label, clk, rst, prop, msg)
`define BCS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- sv/bcs_pkg.sv -----
// Shared constants, types and functions of the biquad cascade unit.
`default_nettype none
package bcs_pkg;

   localparam int MAX_SECTIONS  = 8;
   localparam int SAMPLE_W      = 32;
   localparam int COEF_W        = 32;
   localparam int FRAC_BITS     = 30;
   localparam int COEFS_PER_SEC = 5;
   localparam int HIST_PER_SEC  = 4;
   localparam int COEF_DEPTH    = MAX_SECTIONS * COEFS_PER_SEC;
   localparam int HIST_DEPTH    = MAX_SECTIONS * HIST_PER_SEC;
   localparam int COEF_AW       = $clog2(COEF_DEPTH);
   localparam int HIST_AW       = $clog2(HIST_DEPTH);
   localparam int SEC_W         = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W         = $clog2(MAX_SECTIONS + 1);
   localparam int CFG_SEC_W     = 4;
   localparam int CSR_IDX_W     = 2;
   localparam int SEL_W         = 3;
   localparam int PROD_W        = SAMPLE_W + COEF_W;
   localparam int ACC_W         = PROD_W + 3;
   localparam int RND_W         = ACC_W - FRAC_BITS;

   localparam logic [CSR_IDX_W-1:0] CSR_SECTIONS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MAX  = 2'd2;

   localparam logic [CFG_SEC_W-1:0]       SECTIONS_RST = 4'd1;
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN_RST  = -32'sd327680;
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX_RST  = 32'sd327680;

   localparam logic ACT_FILTER = 1'b0;
   localparam logic ACT_LOAD   = 1'b1;

   localparam logic [SEL_W-1:0] COEF_B0 = 3'd0;
   localparam logic [SEL_W-1:0] COEF_B1 = 3'd1;
   localparam logic [SEL_W-1:0] COEF_B2 = 3'd2;
   localparam logic [SEL_W-1:0] COEF_A1 = 3'd3;
   localparam logic [SEL_W-1:0] COEF_A2 = 3'd4;

   localparam logic [1:0] HS_X1 = 2'd0;
   localparam logic [1:0] HS_X2 = 2'd1;
   localparam logic [1:0] HS_Y1 = 2'd2;
   localparam logic [1:0] HS_Y2 = 2'd3;

   typedef struct packed {
      logic valid;
      logic first;
      logic neg;
      logic use_x0;
   } mac_op_type;

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [RND_W-1:0] v
   );
      logic signed [RND_W-1:0] hi;
      logic signed [RND_W-1:0] lo;
      hi = {{(RND_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[SAMPLE_W-1:0];
      end else if (v < lo) begin
         return lo[SAMPLE_W-1:0];
      end
      return v[SAMPLE_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- sv/bcs_ram.sv -----
// Synchronous RAM with one write and one registered read port; unwritten entries read zero.
`default_nettype none
module bcs_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rdata_ff;
   logic             rvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule
`default_nettype wire

// ----- sv/bcs_mac.sv -----
// Shared multiply-accumulate with round-half-up scaling of the section sum.
`default_nettype none
module bcs_mac (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire bcs_pkg::mac_op_type                    op,
   input  wire logic signed [bcs_pkg::SAMPLE_W-1:0]    x0,
   input  wire logic signed [bcs_pkg::SAMPLE_W-1:0]    hist_rd,
   input  wire logic signed [bcs_pkg::COEF_W-1:0]      coef_rd,
   output logic signed      [bcs_pkg::RND_W-1:0]       y_rnd
);
   import bcs_pkg::*;

   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

   mac_op_type                op_ff;
   logic                      pvalid_ff;
   logic                      pfirst_ff;
   logic                      pneg_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [SAMPLE_W-1:0] x_opnd;
   logic signed [ACC_W-1:0]   p_ext;
   logic signed [ACC_W-1:0]   addend;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   rnd_sum;

   always_comb begin
      x_opnd  = op_ff.use_x0 ? x0 : hist_rd;
      prod_in = x_opnd * coef_rd;
      p_ext   = ACC_W'(prod_ff);
      addend  = pneg_ff ? -p_ext : p_ext;
      acc_in  = (pfirst_ff ? '0 : acc_ff) + addend;
      rnd_sum = acc_ff + RND_HALF;
      y_rnd   = rnd_sum[ACC_W-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= '0;
         pvalid_ff <= 1'b0;
      end else begin
         op_ff     <= op;
         pvalid_ff <= op_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      pfirst_ff <= op_ff.first;
      pneg_ff   <= op_ff.neg;
      prod_ff   <= prod_in;
      if (pvalid_ff) begin
         acc_ff <= acc_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/biquad_cascade_saturating_unit.sv -----
// Top level of the cascaded direct-form-1 biquad filter with clamped output.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  action, sample_in, section_index,
//                                              coef_select, coef_value
//   rsp      out        rsp_valid / rsp_stall  filtered_out, clipped
//   csr      in         csr_wr_en              csr_index, csr_wr_data
//
// A filter item holds req_stall until it has left the finish state. Each of the n sections in
// use runs five products through the one shared multiplier and four history writes through
// the single write port of the history RAM. A coefficient load leaves the block idle. With
// no sections in use an item goes straight from idle to the finish state.
// Reset clears both stores (valid bits) and sets the limits and the section count to their reset values.
// The next item is taken while a result waits on rsp_stall; a second result holds
// in the finish state until the output register frees.
`default_nettype none
`include "assert_macros.svh"
module biquad_cascade_saturating_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_action,
   input  wire logic signed [bcs_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  wire logic [bcs_pkg::SEC_W-1:0]            req_section_index,
   input  wire logic [bcs_pkg::SEL_W-1:0]            req_coef_select,
   input  wire logic signed [bcs_pkg::COEF_W-1:0]    req_coef_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [bcs_pkg::SAMPLE_W-1:0]       rsp_filtered_out,
   output logic                                      rsp_clipped,
   input  wire logic                                 csr_wr_en,
   input  wire logic [bcs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [bcs_pkg::SAMPLE_W-1:0]         csr_wr_data
);
   import bcs_pkg::*;

   localparam int STEP_W = 3;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam logic [STEP_W-1:0] STP_RD_X1 = 3'd0;
   localparam logic [STEP_W-1:0] STP_RD_X2 = 3'd1;
   localparam logic [STEP_W-1:0] STP_RD_Y1 = 3'd2;
   localparam logic [STEP_W-1:0] STP_RD_Y2 = 3'd3;
   localparam logic [STEP_W-1:0] STP_RD_B0 = 3'd4;
   localparam logic [STEP_W-1:0] STP_WB    = 3'd7;

   logic [1:0]                state_ff, state_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [SEC_W-1:0]          sec_ff, sec_in;
   logic [CNT_W-1:0]          nsec_ff, nsec_in;
   logic [COEF_AW-1:0]        coef_base_ff, coef_base_in;
   logic [HIST_AW-1:0]        hist_base_ff, hist_base_in;
   logic signed [SAMPLE_W-1:0] cur_x_ff, cur_x_in;
   logic signed [SAMPLE_W-1:0] x1_ff, x1_in;
   logic signed [SAMPLE_W-1:0] y1_ff, y1_in;
   logic signed [SAMPLE_W-1:0] res_ff, res_in;
   logic                      res_clip_ff, res_clip_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_out_ff, rsp_out_in;
   logic                      rsp_clip_ff, rsp_clip_in;
   logic [CFG_SEC_W-1:0]      sec_use_ff;
   logic signed [SAMPLE_W-1:0] out_min_ff;
   logic signed [SAMPLE_W-1:0] out_max_ff;

   logic [CNT_W-1:0]          n_eff;
   logic                      last_sec;
   logic                      ld_ok;
   logic [COEF_AW-1:0]        ld_addr;
   logic                      issuing;
   mac_op_type                mac_op;
   logic [SEL_W-1:0]          coef_off;
   logic [COEF_AW-1:0]        coef_ra;
   logic [HIST_AW-1:0]        hist_ra;
   logic                      coef_we;
   logic                      hist_we;
   logic [HIST_AW-1:0]        hist_wa;
   logic signed [SAMPLE_W-1:0] hist_wd;
   logic [COEF_W-1:0]         coef_rd;
   logic [SAMPLE_W-1:0]       hist_rd;
   logic signed [RND_W-1:0]   y_rnd;
   logic signed [RND_W-1:0]   lim_lo;
   logic signed [RND_W-1:0]   lim_hi;
   logic signed [RND_W-1:0]   y_clamp;
   logic                      y_clip;
   logic signed [SAMPLE_W-1:0] y_sat;
   logic signed [SAMPLE_W-1:0] y_wr;

   bcs_ram #(
      .DEPTH(COEF_DEPTH),
      .WIDTH(COEF_W)
   ) u_coef_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (coef_we),
      .wr_addr (ld_addr),
      .wr_data (req_coef_value),
      .rd_en   (issuing),
      .rd_addr (coef_ra),
      .rd_data (coef_rd)
   );

   bcs_ram #(
      .DEPTH(HIST_DEPTH),
      .WIDTH(SAMPLE_W)
   ) u_hist_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (hist_we),
      .wr_addr (hist_wa),
      .wr_data (hist_wd),
      .rd_en   (issuing),
      .rd_addr (hist_ra),
      .rd_data (hist_rd)
   );

   bcs_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .op      (mac_op),
      .x0      (cur_x_ff),
      .hist_rd (hist_rd),
      .coef_rd (coef_rd),
      .y_rnd   (y_rnd)
   );

   always_comb begin
      n_eff = (int'(sec_use_ff) > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS) : CNT_W'(sec_use_ff);
      last_sec = (CNT_W'(sec_ff) == (nsec_ff - CNT_W'(1)));
      ld_ok = (int'(req_section_index) < MAX_SECTIONS) && (req_coef_select <= COEF_A2);
      ld_addr = COEF_AW'(req_section_index) * COEF_AW'(COEFS_PER_SEC)
              + COEF_AW'(req_coef_select);

      issuing = (state_ff == ST_RUN) && (step_ff <= STP_RD_B0);
      mac_op.valid  = issuing;
      mac_op.first  = (step_ff == STP_RD_X1);
      mac_op.neg    = (step_ff == STP_RD_Y1) || (step_ff == STP_RD_Y2);
      mac_op.use_x0 = (step_ff == STP_RD_B0);

      case (step_ff)
         STP_RD_X1: coef_off = COEF_B1;
         STP_RD_X2: coef_off = COEF_B2;
         STP_RD_Y1: coef_off = COEF_A1;
         STP_RD_Y2: coef_off = COEF_A2;
         default:   coef_off = COEF_B0;
      endcase
      coef_ra = coef_base_ff + COEF_AW'(coef_off);
      hist_ra = hist_base_ff + HIST_AW'(step_ff[1:0]);

      lim_lo  = RND_W'(out_min_ff);
      lim_hi  = RND_W'(out_max_ff);
      y_clamp = (y_rnd < lim_lo) ? lim_lo : ((y_rnd > lim_hi) ? lim_hi : y_rnd);
      y_clip  = (y_clamp != y_rnd);
      y_sat   = sat_sample(y_rnd);
      y_wr    = last_sec ? y_clamp[SAMPLE_W-1:0] : y_sat;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      sec_in       = sec_ff;
      nsec_in      = nsec_ff;
      coef_base_in = coef_base_ff;
      hist_base_in = hist_base_ff;
      cur_x_in     = cur_x_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      res_in       = res_ff;
      res_clip_in  = res_clip_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_out_in   = rsp_out_ff;
      rsp_clip_in  = rsp_clip_ff;
      coef_we      = 1'b0;
      hist_we      = 1'b0;
      hist_wa      = hist_base_ff;
      hist_wd      = cur_x_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_LOAD) begin
                  coef_we = ld_ok;
               end else if (n_eff == '0) begin
                  res_in      = req_sample_in;
                  res_clip_in = 1'b0;
                  state_in    = ST_FINISH;
               end else begin
                  cur_x_in     = req_sample_in;
                  sec_in       = '0;
                  step_in      = STP_RD_X1;
                  coef_base_in = '0;
                  hist_base_in = '0;
                  nsec_in      = n_eff;
                  state_in     = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            step_in = step_ff + STEP_W'(1);
            case (step_ff)
               STP_RD_X2: begin
                  x1_in   = hist_rd;
                  hist_we = 1'b1;
                  hist_wa = hist_base_ff + HIST_AW'(HS_X1);
                  hist_wd = cur_x_ff;
               end
               STP_RD_Y1: begin
                  hist_we = 1'b1;
                  hist_wa = hist_base_ff + HIST_AW'(HS_X2);
                  hist_wd = x1_ff;
               end
               STP_RD_Y2: begin
                  y1_in = hist_rd;
               end
               STP_RD_B0: begin
                  hist_we = 1'b1;
                  hist_wa = hist_base_ff + HIST_AW'(HS_Y2);
                  hist_wd = y1_ff;
               end
               STP_WB: begin
                  hist_we = 1'b1;
                  hist_wa = hist_base_ff + HIST_AW'(HS_Y1);
                  hist_wd = y_wr;
                  step_in = STP_RD_X1;
                  if (last_sec) begin
                     res_in      = y_clamp[SAMPLE_W-1:0];
                     res_clip_in = y_clip;
                     state_in    = ST_FINISH;
                  end else begin
                     cur_x_in     = y_sat;
                     sec_in       = sec_ff + SEC_W'(1);
                     coef_base_in = coef_base_ff + COEF_AW'(COEFS_PER_SEC);
                     hist_base_in = hist_base_ff + HIST_AW'(HIST_PER_SEC);
                  end
               end
               default: begin
               end
            endcase
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_out_in   = res_ff;
               rsp_clip_in  = res_clip_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STP_RD_X1;
         sec_ff       <= '0;
         nsec_ff      <= '0;
         coef_base_ff <= '0;
         hist_base_ff <= '0;
         rsp_valid_ff <= 1'b0;
         sec_use_ff   <= SECTIONS_RST;
         out_min_ff   <= OUT_MIN_RST;
         out_max_ff   <= OUT_MAX_RST;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sec_ff       <= sec_in;
         nsec_ff      <= nsec_in;
         coef_base_ff <= coef_base_in;
         hist_base_ff <= hist_base_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SECTIONS: sec_use_ff <= csr_wr_data[CFG_SEC_W-1:0];
               CSR_OUT_MIN:  out_min_ff <= csr_wr_data;
               CSR_OUT_MAX:  out_max_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      res_ff      <= res_in;
      res_clip_ff <= res_clip_in;
      rsp_out_ff  <= rsp_out_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_out = rsp_out_ff;
   assign rsp_clipped      = rsp_clip_ff;

   `BCS_ASSERT(a_filter_starts, clock, reset, (req_valid && !req_stall && req_action == ACT_FILTER) |=> req_stall, "filter item did not start")
   `BCS_ASSERT(a_load_silent, clock, reset, (req_valid && !req_stall && req_action == ACT_LOAD && !rsp_valid) |=> !rsp_valid, "load produced a result")
   `BCS_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid) |-> $past(state_ff == ST_FINISH), "result raised outside finish")
   `BCS_ASSERT(a_sec_bound, clock, reset, (state_ff == ST_RUN) |-> (CNT_W'(sec_ff) < nsec_ff), "section beyond count")
   `BCS_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> (!rsp_valid && !req_stall), "reset left block busy")

endmodule
`default_nettype wire

// ----- tb/biquad_cascade_saturating_unit_tb.sv -----
// Self-checking testbench for the cascaded biquad filter unit with clamped output.
`timescale 1ns / 1ps
module biquad_cascade_saturating_unit_tb;
   import bcs_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 8 * MAX_SECTIONS + 2 + 14;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 70;
   localparam int MAX_REPORTS     = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic signed [ACC_W-1:0] SAMPLE_HI =
      {{(ACC_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAMPLE_LO  = ~SAMPLE_HI;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = 1 << (FRAC_BITS - 1);

   typedef struct {
      logic                       action;
      logic signed [SAMPLE_W-1:0] sample;
      logic [SEC_W-1:0]           section;
      logic [SEL_W-1:0]           select;
      logic signed [COEF_W-1:0]   coef;
   } req_item_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       clipped;
   } filter_result_type;

   class cascade_checker;
      logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];
      logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
      logic [CFG_SEC_W-1:0]       sections;
      logic signed [SAMPLE_W-1:0] lim_lo;
      logic signed [SAMPLE_W-1:0] lim_hi;
      filter_result_type          expected_outputs [$];
      int                         errors;
      int                         reported;

      function void clear();
         foreach (coef_mem[i]) coef_mem[i] = '0;
         foreach (hist_mem[i]) hist_mem[i] = '0;
         sections = SECTIONS_RST;
         lim_lo   = OUT_MIN_RST;
         lim_hi   = OUT_MAX_RST;
         expected_outputs.delete();
         errors   = 0;
         reported = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
         case (idx)
            CSR_SECTIONS: sections = data[CFG_SEC_W-1:0];
            CSR_OUT_MIN:  lim_lo = data;
            CSR_OUT_MAX:  lim_hi = data;
            default: ;
         endcase
      endfunction

      function logic signed [ACC_W-1:0] product(logic signed [SAMPLE_W-1:0] x,
                                                logic signed [COEF_W-1:0] c);
         logic signed [ACC_W-1:0] xe;
         logic signed [ACC_W-1:0] ce;
         xe = x;
         ce = c;
         return xe * ce;
      endfunction

      function void take_item(req_item_type it);
         logic signed [ACC_W-1:0]    acc;
         logic signed [ACC_W-1:0]    rounded;
         logic signed [ACC_W-1:0]    y;
         logic signed [SAMPLE_W-1:0] x0;
         logic signed [SAMPLE_W-1:0] y_stage;
         filter_result_type          res;
         int                         n;
         int                         cb;
         int                         hb;
         if (it.action == ACT_LOAD) begin
            if (it.section < MAX_SECTIONS && it.select <= COEF_A2)
               coef_mem[it.section * COEFS_PER_SEC + it.select] = it.coef;
            return;
         end
         n = (sections > MAX_SECTIONS) ? MAX_SECTIONS : sections;
         res.clipped = 1'b0;
         x0 = it.sample;
         for (int k = 0; k < n; k++) begin
            cb = k * COEFS_PER_SEC;
            hb = k * HIST_PER_SEC;
            acc = product(x0, coef_mem[cb + COEF_B0])
                + product(hist_mem[hb + HS_X1], coef_mem[cb + COEF_B1])
                + product(hist_mem[hb + HS_X2], coef_mem[cb + COEF_B2])
                - product(hist_mem[hb + HS_Y1], coef_mem[cb + COEF_A1])
                - product(hist_mem[hb + HS_Y2], coef_mem[cb + COEF_A2]);
            rounded = (acc + ROUND_HALF) >>> FRAC_BITS;
            if (k == n - 1) begin
               if (rounded < lim_lo) y = lim_lo;
               else if (rounded > lim_hi) y = lim_hi;
               else y = rounded;
               res.clipped = (y != rounded);
            end else begin
               if (rounded > SAMPLE_HI) y = SAMPLE_HI;
               else if (rounded < SAMPLE_LO) y = SAMPLE_LO;
               else y = rounded;
            end
            y_stage = y[SAMPLE_W-1:0];
            hist_mem[hb + HS_Y2] = hist_mem[hb + HS_Y1];
            hist_mem[hb + HS_Y1] = y_stage;
            hist_mem[hb + HS_X2] = hist_mem[hb + HS_X1];
            hist_mem[hb + HS_X1] = x0;
            x0 = y_stage;
         end
         res.filtered = x0;
         expected_outputs.push_back(res);
      endfunction

      function void note_error(string msg);
         errors++;
         if (reported < MAX_REPORTS) begin
            reported++;
            $display("%s", msg);
         end
      endfunction

      function void check_output(logic signed [SAMPLE_W-1:0] got, logic clip);
         filter_result_type exp;
         if (expected_outputs.size() == 0) begin
            note_error($sformatf("unexpected output: filtered_out %0d clipped %0b", got, clip));
            return;
         end
         exp = expected_outputs.pop_front();
         if (exp.filtered !== got || exp.clipped !== clip)
            note_error($sformatf("mismatch: filtered_out exp %0d got %0d, clipped exp %0b got %0b",
                                 exp.filtered, got, exp.clipped, clip));
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

      function void check_leftover();
         foreach (expected_outputs[i])
            note_error($sformatf("missing output: filtered_out %0d clipped %0b",
                                 expected_outputs[i].filtered, expected_outputs[i].clipped));
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_action = ACT_FILTER;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic [SEC_W-1:0]           req_section_index = '0;
   logic [SEL_W-1:0]           req_coef_select = '0;
   logic signed [COEF_W-1:0]   req_coef_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_filtered_out;
   logic                       rsp_clipped;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [SAMPLE_W-1:0]        csr_wr_data = '0;

   cascade_checker sb;
   bit             calm = 1'b0;
   int             quiet_cycles = 0;

   biquad_cascade_saturating_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_sample_in     (req_sample_in),
      .req_section_index (req_section_index),
      .req_coef_select   (req_coef_select),
      .req_coef_value    (req_coef_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_filtered_out  (rsp_filtered_out),
      .rsp_clipped       (rsp_clipped),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample(bit tame);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         1, 2: return $urandom;
         default: return tame ? int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000
                              : $urandom;
      endcase
   endfunction

   function automatic logic signed [COEF_W-1:0] rand_coef(bit tame);
      if (tame) return int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
      return $urandom;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_output(rsp_filtered_out, rsp_clipped);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int n;
      forever begin
         n = gap_len();
         rsp_stall <= (n != 0);
         repeat ((n == 0) ? 1 : n) @(negedge clock);
         if (n != 0) begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   task automatic drive_item(req_item_type it);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= it.action;
      req_sample_in     <= it.sample;
      req_section_index <= it.section;
      req_coef_select   <= it.select;
      req_coef_value    <= it.coef;
      do @(posedge clock); while (req_stall);
      sb.take_item(it);
      @(negedge clock);
   endtask

   task automatic send_filter(logic signed [SAMPLE_W-1:0] sample);
      req_item_type it;
      it.action  = ACT_FILTER;
      it.sample  = sample;
      it.section = SEC_W'($urandom);
      it.select  = SEL_W'($urandom);
      it.coef    = $urandom;
      drive_item(it);
   endtask

   task automatic send_load(logic [SEC_W-1:0] sec, logic [SEL_W-1:0] sel,
                            logic signed [COEF_W-1:0] value);
      req_item_type it;
      it.action  = ACT_LOAD;
      it.sample  = $urandom;
      it.section = sec;
      it.select  = sel;
      it.coef    = value;
      drive_item(it);
   endtask

   task automatic program_reg(logic [CSR_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int                         nsec;
      int                         mode;
      int                         i;
      bit                         tame;
      logic signed [SAMPLE_W-1:0] a;
      logic signed [SAMPLE_W-1:0] b;
      sb = new();
      sb.clear();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty coefficients, then unit gain against the reset limits
      send_filter(32'sh7FFF_FFFF);
      send_filter(32'sh8000_0000);
      send_load(SEC_W'(0), COEF_B0, 32'sh4000_0000);
      send_filter(32'sh0001_0000);
      send_filter(32'sh7FFF_FFFF);
      send_filter(32'sh8000_0000);
      send_load(SEC_W'(0), COEF_B1, 32'sh8000_0000);
      send_load(SEC_W'(0), COEF_B2, 32'sh2000_0000);
      send_load(SEC_W'(0), COEF_A1, 32'sh7FFF_FFFF);
      send_load(SEC_W'(0), COEF_A2, 32'shE000_0000);
      for (int sel = COEF_A2 + 1; sel < (1 << SEL_W); sel++)
         send_load(SEC_W'($urandom), SEL_W'(sel), $urandom);
      send_filter(32'sh0003_0000);
      send_filter(32'shFFFD_0000);
      send_filter(0);

      // pass-through with no sections
      settle();
      program_reg(CSR_SECTIONS, 0);
      program_reg(CSR_OUT_MIN, 32'h8000_0000);
      program_reg(CSR_OUT_MAX, 32'h7FFF_FFFF);
      send_filter(32'sh8000_0000);
      send_filter(32'sh7FFF_FFFF);

      // section count above the maximum
      settle();
      program_reg(CSR_SECTIONS, 15);
      for (int s = 1; s < MAX_SECTIONS; s++)
         send_load(SEC_W'(s), COEF_B0, 32'sh4000_0000);
      send_filter(32'sh7FFF_FFFF);
      send_filter(32'sh8000_0000);

      // crossed limits
      settle();
      program_reg(CSR_SECTIONS, 1);
      program_reg(CSR_OUT_MIN, 32'sh0001_0000);
      program_reg(CSR_OUT_MAX, 32'shFFFF_0000);
      send_filter(0);
      send_filter(32'sh0010_0000);
      send_filter(32'shFFF0_0000);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case (p)
            0: nsec = MAX_SECTIONS;
            1: nsec = 15;
            2: nsec = 0;
            default: nsec = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                          : $urandom_range(1, 8);
         endcase
         program_reg(CSR_SECTIONS, nsec);
         mode = (p == 0) ? 0 : $urandom_range(0, 3);
         a = $urandom;
         b = $urandom;
         case (mode)
            0: begin
               a = 32'sh8000_0000;
               b = 32'sh7FFF_FFFF;
            end
            1: if (a > b) {a, b} = {b, a};
            2: if (a < b) {a, b} = {b, a};
            default: begin
               b = $urandom_range(1, 32'h0100_0000);
               a = -b;
            end
         endcase
         program_reg(CSR_OUT_MIN, a);
         program_reg(CSR_OUT_MAX, b);
         if (p == 3) program_reg(CSR_SPARE, $urandom);

         tame = ($urandom_range(0, 3) != 0);
         calm = 1'b0;
         for (int s = 0; s < nsec && s < MAX_SECTIONS; s++)
            for (int sel = COEF_B0; sel <= COEF_A2; sel++)
               send_load(SEC_W'(s), SEL_W'(sel), rand_coef(tame));
         i = 0;
         while (i < ITEMS_PER_PHASE) begin
            if (i % 25 == 0) calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 11) == 0) begin
               send_load(SEC_W'($urandom), SEL_W'($urandom), rand_coef(tame));
            end else begin
               send_filter(rand_sample(tame));
               i++;
            end
         end
      end

      calm = 1'b0;
      settle();
      sb.check_leftover();
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+sv
sv/bcs_pkg.sv
sv/bcs_ram.sv
sv/bcs_mac.sv
sv/biquad_cascade_saturating_unit.sv
tb/biquad_cascade_saturating_unit_tb.sv
